FILE: rtl/b64u_pkg.sv
// Shared types, constants and the character mapping for the base64url encoder.
package b64u_pkg;

    // ASCII codes used when building characters.
    localparam logic [6:0] PAD_CODE   = 7'd61;  // '='
    localparam logic [6:0] DASH_CODE  = 7'd45;  // '-'
    localparam logic [6:0] UNDER_CODE = 7'd95;  // '_'
    localparam logic [6:0] UPPER_BASE = 7'd65;  // 'A'
    localparam logic [6:0] LOWER_BASE = 7'd71;  // 'a' minus 26
    localparam logic [6:0] DIGIT_DROP = 7'd4;   // 52 minus '0'

    localparam int MAX_CHARS = 4;

    // Input word: one raw byte and the end-of-message flag.
    typedef struct packed {
        logic [7:0] data_byte;
        logic       final_byte;
    } in_word_t;

    // Output word: one ASCII character and the end-of-message mark.
    typedef struct packed {
        logic [6:0] char_code;
        logic       message_end;
    } out_word_t;

    // Encoder state carried from one byte to the next.
    typedef struct packed {
        logic [5:0] pending_bits;
        logic [2:0] pending_count;
        logic [1:0] chars_mod_four;
    } enc_state_t;

    // Group of characters produced by one byte.
    typedef struct packed {
        logic [MAX_CHARS-1:0][6:0] chars;
        logic [2:0]                count;
        logic                      final_flag;
    } char_group_t;

    // Maps a six-bit value to its URL-safe alphabet symbol.
    function automatic logic [6:0] symbol(input logic [5:0] v);
        logic [6:0] code;
        if (v < 6'd26) begin
            code = UPPER_BASE + {1'b0, v};
        end else if (v < 6'd52) begin
            code = LOWER_BASE + {1'b0, v};
        end else if (v < 6'd62) begin
            code = {1'b0, v} - DIGIT_DROP;
        end else if (v == 6'd62) begin
            code = DASH_CODE;
        end else begin
            code = UNDER_CODE;
        end
        return code;
    endfunction

endpackage

FILE: rtl/b64u_group.sv
// Turns one byte and the current encoder state into its character group.
module b64u_group (
    input  b64u_pkg::in_word_t    word,
    input  b64u_pkg::enc_state_t  state,
    output b64u_pkg::char_group_t group,
    output b64u_pkg::enc_state_t  state_next
);

    logic [5:0] c0;
    logic [5:0] c1;
    logic [5:0] flush;
    logic [3:0] rem;
    logic [2:0] rem_count;
    logic [1:0] n_regular;
    logic [1:0] mod_after;
    logic [1:0] pads;
    logic [7:0] d;
    logic [5:0] p;

    assign d = word.data_byte;
    assign p = state.pending_bits;

    always_comb
    begin
        case (state.pending_count)
            3'd0:
            begin
                c0        = d[7:2];
                c1        = '0;
                n_regular = 2'd1;
                rem       = {2'b00, d[1:0]};
                rem_count = 3'd2;
                flush     = {d[1:0], 4'b0000};
            end
            3'd2:
            begin
                c0        = {p[1:0], d[7:4]};
                c1        = '0;
                n_regular = 2'd1;
                rem       = d[3:0];
                rem_count = 3'd4;
                flush     = {d[3:0], 2'b00};
            end
            default:
            begin
                c0        = {p[3:0], d[7:6]};
                c1        = d[5:0];
                n_regular = 2'd2;
                rem       = '0;
                rem_count = 3'd0;
                flush     = '0;
            end
        endcase
    end

    // A final byte always yields exactly two characters before padding: either
    // two full groups, or one full group and the flushed leftover bits.
    assign mod_after = state.chars_mod_four + 2'd2;
    assign pads      = (mod_after == 2'd0) ? 2'd0 : 2'd2 - ((mod_after == 2'd3) ? 2'd1 : 2'd0);

    always_comb
    begin
        group.chars[0]   = b64u_pkg::symbol(c0);
        group.chars[1]   = (n_regular == 2'd2) ? b64u_pkg::symbol(c1)
                                               : b64u_pkg::symbol(flush);
        group.chars[2]   = b64u_pkg::PAD_CODE;
        group.chars[3]   = b64u_pkg::PAD_CODE;
        group.final_flag = word.final_byte;
        if (word.final_byte) begin
            group.count               = 3'd2 + {1'b0, pads};
            state_next.pending_bits   = '0;
            state_next.pending_count  = '0;
            state_next.chars_mod_four = '0;
        end else begin
            group.count               = {1'b0, n_regular};
            state_next.pending_bits   = {2'b00, rem};
            state_next.pending_count  = rem_count;
            state_next.chars_mod_four = state.chars_mod_four + n_regular;
        end
    end

endmodule

FILE: rtl/base64url_stream_encoder_core.sv
// Top level of the streaming base64url encoder: byte input, character output.
// The block takes a message one byte per word and gives base64url text one
// character per word, using the URL-safe alphabet (A-Z, a-z, 0-9, '-', '_').
// The byte that carries final_byte flushes any leftover bits as one more
// character (left-aligned, zero-filled), pads with '=' to a multiple of four
// characters, raises message_end on the last character and clears the state
// for the next message. Every message has at least one byte. A byte enters an
// input register, is encoded combinationally into a group of one to four
// characters, and the group is sent out at one character per cycle while
// char_stall is low, so the output port sets the rate: a non-final byte gives
// one or two characters and a final byte two to four. A byte's characters
// are shown from the group register, which loads from the input register.
// The input register takes the next byte while the current group drains.
module base64url_stream_encoder_core (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 byte_valid,
    output logic                 byte_stall,
    input  b64u_pkg::in_word_t   byte_word,
    output logic                 char_valid,
    input  logic                 char_stall,
    output b64u_pkg::out_word_t  char_word
);

    // Input register.
    logic                  in_full_reg;
    b64u_pkg::in_word_t    in_word_reg;

    // Encoder state between bytes.
    b64u_pkg::enc_state_t  state_reg;
    b64u_pkg::enc_state_t  state_next;

    // Character group being sent out.
    logic                  group_valid_reg;
    b64u_pkg::char_group_t group_reg;
    b64u_pkg::char_group_t group_next;
    logic [1:0]            idx_reg;

    logic [1:0]            last_idx;
    logic                  on_last;
    logic                  pop;
    logic                  last_pop;
    logic                  load;

    b64u_group u_group (
        .word       (in_word_reg),
        .state      (state_reg),
        .group      (group_next),
        .state_next (state_next)
    );

    assign last_idx = 2'(group_reg.count - 3'd1);
    assign on_last  = (idx_reg == last_idx);
    assign pop      = group_valid_reg && !char_stall;
    assign last_pop = pop && on_last;

    // The held byte moves on when the group register is free or frees up now.
    assign load       = in_full_reg && (!group_valid_reg || last_pop);
    assign byte_stall = in_full_reg && !load;

    assign char_valid            = group_valid_reg;
    assign char_word.char_code   = group_reg.chars[idx_reg];
    assign char_word.message_end = group_reg.final_flag && on_last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            in_full_reg <= 1'b0;
        end else if (!byte_stall) begin
            in_full_reg <= byte_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (byte_valid && !byte_stall) begin
            in_word_reg <= byte_word;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg       <= '0;
            group_valid_reg <= 1'b0;
            idx_reg         <= '0;
        end else if (load) begin
            state_reg       <= state_next;
            group_valid_reg <= 1'b1;
            idx_reg         <= '0;
        end else if (last_pop) begin
            group_valid_reg <= 1'b0;
        end else if (pop) begin
            idx_reg <= idx_reg + 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load) begin
            group_reg <= group_next;
        end
    end

endmodule

FILE: verif/tb.sv
// Self-checking testbench for the streaming base64url encoder core.
module tb;

    // The watchdog ends the run after this many cycles with no word accepted on either side.
    localparam int QUIET_LIMIT = 4000;
    // Cycles allowed after the last expected character, for stray words to show up.
    localparam int TAIL_CYCLES = 20;
    // Length of the long receiver hold-off used to back the encoder up.
    localparam int HOLD_CYCLES = 300;

    logic                clk;
    logic                rst_n = 1'b0;
    logic                byte_valid = 1'b0;
    logic                byte_stall;
    b64u_pkg::in_word_t  byte_word = '0;
    logic                char_valid;
    logic                char_stall = 1'b0;
    b64u_pkg::out_word_t char_word;

    // Idling controls, set by each test; percentages of cycles.
    int unsigned send_idle_pct = 0;
    int unsigned recv_stall_pct = 0;

    // A test bumps hold_request to ask for one long hold-off; the receiver
    // process notices the change and counts the hold-off down itself.
    int unsigned hold_request = 0;
    int unsigned hold_seen = 0;
    int unsigned hold_left = 0;

    int unsigned mismatch_count = 0;
    int unsigned quiet_cycles = 0;

    // Characters the encoder still owes us, oldest first.
    b64u_pkg::out_word_t expected_chars[$];

    // Encoder state as the predictor sees it.
    logic [5:0] enc_bits = '0;
    logic [2:0] enc_count = '0;
    logic [1:0] enc_chars_mod4 = '0;

    string url_alphabet =
        "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789-_";

    base64url_stream_encoder_core DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_valid (byte_valid),
        .byte_stall (byte_stall),
        .byte_word  (byte_word),
        .char_valid (char_valid),
        .char_stall (char_stall),
        .char_word  (char_word)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic logic [6:0] url_symbol(input logic [5:0] v);
        return 7'(url_alphabet[v]);
    endfunction

    // Predicts the characters that one accepted byte produces and queues them.
    // Whole six-bit groups go out at once, most significant first. A final byte
    // also flushes leftover bits left-aligned, pads with '=' to a multiple of
    // four characters and clears the state.
    task automatic encode_byte(input b64u_pkg::in_word_t w);
        logic [13:0]         acc;
        logic [13:0]         keep_mask;
        logic [6:0]          chars [4];
        int unsigned         cnt;
        int                  n;
        b64u_pkg::out_word_t o;
        acc = {enc_bits, w.data_byte};
        cnt = enc_count + 8;
        n = 0;
        while (cnt >= 6)
        begin
            cnt -= 6;
            chars[n] = url_symbol(acc[cnt +: 6]);
            n++;
            enc_chars_mod4++;
        end
        keep_mask = (14'd1 << cnt) - 14'd1;
        acc = acc & keep_mask;
        if (!w.final_byte)
        begin
            enc_bits = acc[5:0];
            enc_count = 3'(cnt);
        end
        else
        begin
            if (cnt != 0)
            begin
                chars[n] = url_symbol(6'(acc << (6 - cnt)));
                n++;
                enc_chars_mod4++;
            end
            while (enc_chars_mod4 != 0 && n < b64u_pkg::MAX_CHARS)
            begin
                chars[n] = b64u_pkg::PAD_CODE;
                n++;
                enc_chars_mod4++;
            end
            enc_bits = '0;
            enc_count = '0;
            enc_chars_mod4 = '0;
        end
        for (int i = 0; i < n; i++)
        begin
            o.char_code = chars[i];
            o.message_end = w.final_byte && (i == n - 1);
            expected_chars.push_back(o);
        end
    endtask

    // Offers one byte word, holds it steady while stalled, and predicts its
    // characters once it is taken. Valid is left high so that back-to-back
    // words need no gap.
    task automatic send_byte(input logic [7:0] data, input logic last);
        b64u_pkg::in_word_t w;
        w.data_byte = data;
        w.final_byte = last;
        while ($urandom_range(99) < send_idle_pct)
        begin
            byte_valid <= 1'b0;
            @(posedge clk);
        end
        byte_valid <= 1'b1;
        byte_word <= w;
        @(posedge clk);
        while (byte_stall)
            @(posedge clk);
        encode_byte(w);
    endtask

    // Sends a whole message of random bytes, the final flag on the last one.
    task automatic send_random_message(input int len);
        for (int i = 0; i < len; i++)
            send_byte(8'($urandom_range(255)), i == len - 1);
    endtask

    // Sends exactly the given number of bytes as complete messages of random length.
    task automatic send_random_bytes(input int total);
        int sent;
        int len;
        sent = 0;
        while (sent < total)
        begin
            len = $urandom_range(1, 9);
            if ($urandom_range(9) == 0)
                len = 1;
            if (len > total - sent)
                len = total - sent;
            send_random_message(len);
            sent += len;
        end
    endtask

    // Drops valid and waits until every predicted character has come out.
    task automatic wait_for_drain();
        byte_valid <= 1'b0;
        while (expected_chars.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Byte extremes, every remainder of the message length modulo three, and
    // messages that are one byte long.
    task automatic test_directed();
        send_byte(8'h00, 1'b1);
        send_byte(8'hFF, 1'b1);
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b1);
        send_byte(8'hFB, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'hBF, 1'b1);
        send_byte(8'hFF, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'hFF, 1'b1);
        send_byte(8'h55, 1'b0);
        send_byte(8'hAA, 1'b0);
        send_byte(8'h80, 1'b0);
        send_byte(8'h01, 1'b0);
        send_byte(8'h7F, 1'b1);
        send_byte(8'h00, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h00, 1'b1);
        send_byte(8'hF8, 1'b1);
    endtask

    task automatic test_no_idling();
        send_idle_pct = 0;
        recv_stall_pct = 0;
        send_random_bytes(18);
    endtask

    task automatic test_sender_idle();
        send_idle_pct = 87;
        recv_stall_pct = 0;
        send_random_bytes(18);
    endtask

    task automatic test_receiver_stall();
        send_idle_pct = 0;
        recv_stall_pct = 87;
        send_random_bytes(18);
    endtask

    task automatic test_both_idle();
        send_idle_pct = 19;
        recv_stall_pct = 19;
        send_random_bytes(18);
    endtask

    // The receiver stops taking characters for a long stretch while the sender
    // keeps offering bytes, so the encoder fills up and stalls its input.
    task automatic test_receiver_hold_off();
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_request++;
        send_random_bytes(10);
    endtask

    // The sender pauses mid-run until everything predicted has come out.
    task automatic test_sender_pause();
        send_idle_pct = 10;
        recv_stall_pct = 10;
        send_random_message(3);
        wait_for_drain();
        send_random_message(5);
    endtask

    // Receiver side: random stall per cycle, or a forced hold-off when one is
    // pending.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            char_stall <= 1'b0;
        end
        else if (hold_left != 0 || hold_request != hold_seen)
        begin
            if (hold_request != hold_seen)
            begin
                hold_seen = hold_request;
                hold_left = HOLD_CYCLES;
            end
            char_stall <= 1'b1;
            hold_left--;
        end
        else
        begin
            char_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    // Compares each accepted character word with the oldest prediction and keeps
    // the count of cycles without progress for the watchdog. Values read here
    // are the ones held before this edge.
    always @(posedge clk)
    begin : check_chars
        b64u_pkg::out_word_t want;
        if (rst_n)
        begin
            if ((byte_valid && !byte_stall) || (char_valid && !char_stall))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (char_valid && !char_stall)
            begin
                if (expected_chars.size() == 0)
                begin
                    $display("%0t: unexpected character word, expected none, got %h",
                             $time, char_word);
                    mismatch_count++;
                end
                else
                begin
                    want = expected_chars.pop_front();
                    if (char_word.char_code !== want.char_code)
                    begin
                        $display("%0t: char_code expected %h got %h",
                                 $time, want.char_code, char_word.char_code);
                        mismatch_count++;
                    end
                    if (char_word.message_end !== want.message_end)
                    begin
                        $display("%0t: message_end expected %b got %b",
                                 $time, want.message_end, char_word.message_end);
                        mismatch_count++;
                    end
                end
            end
        end
    end

    // Watchdog: too long without any word moving means the encoder is stuck.
    initial
    begin
        while (quiet_cycles < QUIET_LIMIT)
            @(posedge clk);
        $display("CHECK FAILED");
        $finish;
    end

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_no_idling();
        test_sender_idle();
        test_receiver_stall();
        test_both_idle();
        test_receiver_hold_off();
        test_sender_pause();
        // All bytes are in; let the last characters out, then allow time for
        // anything extra the encoder might still send.
        wait_for_drain();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && expected_chars.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

FILE: sim.f
rtl/b64u_pkg.sv
rtl/b64u_group.sv
rtl/base64url_stream_encoder_core.sv
verif/tb.sv
